>>> rtl/core/cpsc_pkg.sv
// ----------------------------------------------------------------------------
// cpsc_pkg
// Shared types and constants of the convex polygon collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsc_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  // count holds 0 .. MAX_VERTICES+1, the top value marks overflow
  localparam int CNT_W  = $clog2(MAX_VERTICES + 2);
  localparam int AXIS_W = COORD_BITS + 1;
  localparam int PROD_W = COORD_BITS + AXIS_W;
  localparam int DOT_W  = PROD_W + 1;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] OVF_CNT = CNT_W'(MAX_VERTICES + 1);
  localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(2);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_FEW  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic                         polygon_b;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic                         last_vertex;
  } in_item_t;

  typedef struct packed {
    logic    colliding;
    status_e status;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
  } axis_t;

  // controller to datapath
  typedef struct packed {
    logic              wr_en;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    vertex_t           wr_vtx;
    logic [ADDR_W-1:0] rd_addr;
    logic              edge_b;
    logic              cap_i;
    logic              cap_axis;
    logic              lane_vld_a;
    logic              lane_vld_b;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic axis_sep;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/convex_polygon_sat_collision.sv
// ----------------------------------------------------------------------------
// convex_polygon_sat_collision
// Separating-axis collision test of two convex 2D polygons.
// ----------------------------------------------------------------------------
// Usage: vertices enter on the in channel (valid/ready), one per transfer,
// polygon A first and then polygon B.
// The transfer that carries the last vertex of B starts the test; the block
// then takes no input until the result is loaded into the output register.
// Test steps: a check, then for each edge of A and of B reads of vertex i and
// j, the axis, projection steps for vertex indices below max(na, nb) on both
// lanes at once, a multiply/add drain and a compare. The test stops at the
// first separating axis. Bad vertex counts answer straight after the check.
// The projection lanes use one read port per polygon memory.
// The result sits in an output register; while the receiver stalls, vertices
// of the next pair are still taken, but a new test waits to deliver its result
// until the old one is transferred. Reset clears counts and the output valid;
// vertex memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_polygon_sat_collision (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire cpsc_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output cpsc_pkg::out_item_t       out_data_o
);

  cpsc_pkg::cmd_t    cmd;
  cpsc_pkg::dp_sts_t sts;

  cpsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  cpsc_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire

>>> rtl/core/cpsc_lane.sv
// ----------------------------------------------------------------------------
// cpsc_lane
// Projection lane: dot product of a vertex with the axis, running min/max.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsc_lane (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              clear_i,
  input  wire logic                              vld_i,
  input  wire cpsc_pkg::vertex_t                 vtx_i,
  input  wire cpsc_pkg::axis_t                   axis_i,
  output logic signed [cpsc_pkg::DOT_W-1:0]      lo_o,
  output logic signed [cpsc_pkg::DOT_W-1:0]      hi_o
);

  logic                                 v2_q;
  logic                                 v3_q;
  logic                                 seen_q;
  logic signed [cpsc_pkg::PROD_W-1:0]   px_q;
  logic signed [cpsc_pkg::PROD_W-1:0]   py_q;
  logic signed [cpsc_pkg::PROD_W-1:0]   px_d;
  logic signed [cpsc_pkg::PROD_W-1:0]   py_d;
  logic signed [cpsc_pkg::DOT_W-1:0]    dot_q;
  logic signed [cpsc_pkg::DOT_W-1:0]    dot_d;
  logic signed [cpsc_pkg::DOT_W-1:0]    lo_q;
  logic signed [cpsc_pkg::DOT_W-1:0]    hi_q;

  assign px_d  = cpsc_pkg::PROD_W'(vtx_i.x) * cpsc_pkg::PROD_W'(axis_i.ax);
  assign py_d  = cpsc_pkg::PROD_W'(vtx_i.y) * cpsc_pkg::PROD_W'(axis_i.ay);
  assign dot_d = cpsc_pkg::DOT_W'(px_q) + cpsc_pkg::DOT_W'(py_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      seen_q <= 1'b0;
    end else begin
      v2_q <= vld_i;
      v3_q <= v2_q;
      if (clear_i) begin
        seen_q <= 1'b0;
      end else if (v3_q) begin
        seen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    dot_q <= dot_d;
    if (v3_q) begin
      if (!seen_q || dot_q < lo_q) begin
        lo_q <= dot_q;
      end
      if (!seen_q || dot_q > hi_q) begin
        hi_q <= dot_q;
      end
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

`default_nettype wire

>>> rtl/core/cpsc_dp.sv
// ----------------------------------------------------------------------------
// cpsc_dp
// Datapath: vertex memories, edge fetch, axis forming, two projection lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsc_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cpsc_pkg::cmd_t     cmd_i,
  output cpsc_pkg::dp_sts_t       sts_o
);

  cpsc_pkg::vertex_t mem_a_q [cpsc_pkg::MAX_VERTICES];
  cpsc_pkg::vertex_t mem_b_q [cpsc_pkg::MAX_VERTICES];
  cpsc_pkg::vertex_t rd_a_q;
  cpsc_pkg::vertex_t rd_b_q;
  cpsc_pkg::vertex_t rd_edge;
  cpsc_pkg::vertex_t vi_q;
  cpsc_pkg::axis_t   axis_q;
  cpsc_pkg::axis_t   axis_d;
  logic              v1_a_q;
  logic              v1_b_q;

  logic signed [cpsc_pkg::DOT_W-1:0] lo_a;
  logic signed [cpsc_pkg::DOT_W-1:0] hi_a;
  logic signed [cpsc_pkg::DOT_W-1:0] lo_b;
  logic signed [cpsc_pkg::DOT_W-1:0] hi_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !cmd_i.wr_b) begin
      mem_a_q[cmd_i.wr_addr] <= cmd_i.wr_vtx;
    end
    rd_a_q <= mem_a_q[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.wr_b) begin
      mem_b_q[cmd_i.wr_addr] <= cmd_i.wr_vtx;
    end
    rd_b_q <= mem_b_q[cmd_i.rd_addr];
  end

  assign rd_edge = cmd_i.edge_b ? rd_b_q : rd_a_q;

  // axis is (dy, -dx) for the edge from vertex i to vertex j
  always_comb begin
    axis_d.ax = cpsc_pkg::AXIS_W'(rd_edge.y) - cpsc_pkg::AXIS_W'(vi_q.y);
    axis_d.ay = cpsc_pkg::AXIS_W'(vi_q.x) - cpsc_pkg::AXIS_W'(rd_edge.x);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_i) begin
      vi_q <= rd_edge;
    end
    if (cmd_i.cap_axis) begin
      axis_q <= axis_d;
    end
  end

  // lane tags follow the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_a_q <= 1'b0;
      v1_b_q <= 1'b0;
    end else begin
      v1_a_q <= cmd_i.lane_vld_a;
      v1_b_q <= cmd_i.lane_vld_b;
    end
  end

  cpsc_lane u_lane_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cmd_i.cap_axis),
    .vld_i   (v1_a_q),
    .vtx_i   (rd_a_q),
    .axis_i  (axis_q),
    .lo_o    (lo_a),
    .hi_o    (hi_a)
  );

  cpsc_lane u_lane_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cmd_i.cap_axis),
    .vld_i   (v1_b_q),
    .vtx_i   (rd_b_q),
    .axis_i  (axis_q),
    .lo_o    (lo_b),
    .hi_o    (hi_b)
  );

  assign sts_o.axis_sep = (hi_a < lo_b) || (hi_b < lo_a);

endmodule

`default_nettype wire

>>> rtl/core/cpsc_ctrl.sv
// ----------------------------------------------------------------------------
// cpsc_ctrl
// Controller: vertex intake, counts, edge and projection sequencing, result.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire cpsc_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output cpsc_pkg::out_item_t       out_data_o,
  output cpsc_pkg::cmd_t            cmd_o,
  input  wire cpsc_pkg::dp_sts_t    sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EDGE_I,
    ST_EDGE_J,
    ST_AXIS,
    ST_PROJ,
    ST_DRAIN,
    ST_CMP,
    ST_FINISH
  } state_e;

  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_e                           state_q;
  logic [cpsc_pkg::CNT_W-1:0]       cnt_a_q;
  logic [cpsc_pkg::CNT_W-1:0]       cnt_b_q;
  logic                             a_complete_q;
  logic                             pass_b_q;
  logic [cpsc_pkg::ADDR_W-1:0]      edge_q;
  logic [cpsc_pkg::ADDR_W-1:0]      k_q;
  logic [1:0]                       drain_q;
  logic                             res_col_q;
  cpsc_pkg::status_e                res_status_q;
  logic                             out_valid_q;
  cpsc_pkg::out_item_t              out_data_q;

  logic                             accept;
  logic [cpsc_pkg::CNT_W-1:0]       n_edge;
  logic [cpsc_pkg::CNT_W-1:0]       k_max;
  logic                             edge_last;
  logic                             k_last;
  logic [cpsc_pkg::ADDR_W-1:0]      edge_j;
  logic                             out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign n_edge    = pass_b_q ? cnt_b_q : cnt_a_q;
  assign k_max     = (cnt_a_q > cnt_b_q) ? cnt_a_q : cnt_b_q;
  assign edge_last = (cpsc_pkg::CNT_W'(edge_q) + cpsc_pkg::CNT_W'(1)) == n_edge;
  assign k_last    = (cpsc_pkg::CNT_W'(k_q) + cpsc_pkg::CNT_W'(1)) == k_max;
  // closing edge wraps back to vertex 0
  assign edge_j    = edge_last ? '0 : edge_q + cpsc_pkg::ADDR_W'(1);

  always_comb begin
    cmd_o            = '0;
    cmd_o.wr_b       = in_data_i.polygon_b;
    cmd_o.wr_vtx.x   = in_data_i.x_coord;
    cmd_o.wr_vtx.y   = in_data_i.y_coord;
    cmd_o.edge_b     = pass_b_q;
    cmd_o.rd_addr    = k_q;
    if (in_data_i.polygon_b) begin
      cmd_o.wr_en   = accept && (cnt_b_q < cpsc_pkg::MAX_CNT);
      cmd_o.wr_addr = cnt_b_q[cpsc_pkg::ADDR_W-1:0];
    end else begin
      cmd_o.wr_en   = accept && (a_complete_q || cnt_a_q < cpsc_pkg::MAX_CNT);
      cmd_o.wr_addr = a_complete_q ? '0 : cnt_a_q[cpsc_pkg::ADDR_W-1:0];
    end
    unique case (state_q)
      ST_EDGE_I: begin
        cmd_o.rd_addr = edge_q;
      end
      ST_EDGE_J: begin
        cmd_o.rd_addr = edge_j;
        cmd_o.cap_i   = 1'b1;
      end
      ST_AXIS: begin
        cmd_o.cap_axis = 1'b1;
      end
      ST_PROJ: begin
        cmd_o.lane_vld_a = cpsc_pkg::CNT_W'(k_q) < cnt_a_q;
        cmd_o.lane_vld_b = cpsc_pkg::CNT_W'(k_q) < cnt_b_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_a_q      <= '0;
      cnt_b_q      <= '0;
      a_complete_q <= 1'b0;
      pass_b_q     <= 1'b0;
      edge_q       <= '0;
      k_q          <= '0;
      drain_q      <= '0;
      res_col_q    <= 1'b0;
      res_status_q <= cpsc_pkg::STATUS_OK;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (!in_data_i.polygon_b) begin
              // a vertex of A after A ended starts a fresh pair
              if (a_complete_q) begin
                cnt_a_q <= cpsc_pkg::CNT_W'(1);
                cnt_b_q <= '0;
              end else if (cnt_a_q < cpsc_pkg::MAX_CNT) begin
                cnt_a_q <= cnt_a_q + cpsc_pkg::CNT_W'(1);
              end else begin
                cnt_a_q <= cpsc_pkg::OVF_CNT;
              end
              a_complete_q <= in_data_i.last_vertex;
            end else begin
              if (cnt_b_q < cpsc_pkg::MAX_CNT) begin
                cnt_b_q <= cnt_b_q + cpsc_pkg::CNT_W'(1);
              end else begin
                cnt_b_q <= cpsc_pkg::OVF_CNT;
              end
              if (in_data_i.last_vertex) begin
                state_q <= ST_CHECK;
              end
            end
          end
        end
        ST_CHECK: begin
          res_col_q <= 1'b0;
          pass_b_q  <= 1'b0;
          edge_q    <= '0;
          k_q       <= '0;
          priority if (cnt_a_q > cpsc_pkg::MAX_CNT || cnt_b_q > cpsc_pkg::MAX_CNT) begin
            res_status_q <= cpsc_pkg::STATUS_OVERFLOW;
            state_q      <= ST_FINISH;
          end else if (cnt_a_q < cpsc_pkg::MIN_CNT || cnt_b_q < cpsc_pkg::MIN_CNT) begin
            res_status_q <= cpsc_pkg::STATUS_TOO_FEW;
            state_q      <= ST_FINISH;
          end else begin
            res_status_q <= cpsc_pkg::STATUS_OK;
            state_q      <= ST_EDGE_I;
          end
        end
        ST_EDGE_I: begin
          state_q <= ST_EDGE_J;
        end
        ST_EDGE_J: begin
          state_q <= ST_AXIS;
        end
        ST_AXIS: begin
          k_q     <= '0;
          state_q <= ST_PROJ;
        end
        ST_PROJ: begin
          if (k_last) begin
            k_q     <= '0;
            drain_q <= '0;
            state_q <= ST_DRAIN;
          end else begin
            k_q <= k_q + cpsc_pkg::ADDR_W'(1);
          end
        end
        ST_DRAIN: begin
          // wait until the last dot product has reached min/max
          if (drain_q == DRAIN_LAST) begin
            state_q <= ST_CMP;
          end else begin
            drain_q <= drain_q + 2'd1;
          end
        end
        ST_CMP: begin
          priority if (sts_i.axis_sep) begin
            res_col_q <= 1'b0;
            state_q   <= ST_FINISH;
          end else if (edge_last && pass_b_q) begin
            res_col_q <= 1'b1;
            state_q   <= ST_FINISH;
          end else if (edge_last) begin
            pass_b_q <= 1'b1;
            edge_q   <= '0;
            state_q  <= ST_EDGE_I;
          end else begin
            edge_q  <= edge_j;
            state_q <= ST_EDGE_I;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_data_q.colliding <= res_col_q;
            out_data_q.status    <= res_status_q;
            cnt_a_q              <= '0;
            cnt_b_q              <= '0;
            a_complete_q         <= 1'b0;
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/core/cpsc_checker.sv
// ----------------------------------------------------------------------------
// cpsc_checker
// Port-level checks of the collision block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsc_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire cpsc_pkg::in_item_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire cpsc_pkg::out_item_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // an error status never reports a collision
  a_err_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != cpsc_pkg::STATUS_OK |-> !out_data_o.colliding)
    else $error("collision flagged with error status");

  // the last vertex of B starts a test, input stalls meanwhile
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.polygon_b && in_data_i.last_vertex
    |=> !in_ready_o)
    else $error("input taken right after last vertex of B");

  // a new result only comes out of a test
  a_result_from_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a test");

endmodule

bind convex_polygon_sat_collision cpsc_checker u_cpsc_checker (.*);

`default_nettype wire

>>> bench/convex_polygon_sat_collision_tb.sv
// ----------------------------------------------------------------------------
// convex_polygon_sat_collision_tb
// Streams polygon pairs into the separating-axis collision block and checks
// every verdict against an in-bench copy of the polygon stores and SAT test.
// ----------------------------------------------------------------------------
module convex_polygon_sat_collision_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS      = 1600;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 1000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int COORD_MAX    = 2 ** (cpsc_pkg::COORD_BITS - 1) - 1;
  localparam int COORD_MIN    = -(2 ** (cpsc_pkg::COORD_BITS - 1));

  typedef struct {
    cpsc_pkg::in_item_t item;
    bit                 wait_idle;
  } vertex_req_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  cpsc_pkg::in_item_t  in_data = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_ready = 1'b0;
  cpsc_pkg::out_item_t out_data;

  convex_polygon_sat_collision dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  vertex_req_t         vertex_q[$];
  cpsc_pkg::out_item_t verdict_q[$];
  bit                  pause_next;
  int                  errors;
  int                  cycles;
  int                  sent;
  int                  verdicts_seen;
  int                  n_hit, n_sep, n_few, n_ovf;

  // ---------------------------------------------------------------- predictor
  // index 0 holds polygon A, index 1 polygon B
  logic signed [cpsc_pkg::COORD_BITS-1:0] poly_x [2][cpsc_pkg::MAX_VERTICES];
  logic signed [cpsc_pkg::COORD_BITS-1:0] poly_y [2][cpsc_pkg::MAX_VERTICES];
  int vtx_cnt [2];
  bit a_closed;

  function automatic void span_on_axis(int p, longint ax, longint ay,
                                       output longint lo, output longint hi);
    longint d;
    lo = 0;
    hi = 0;
    for (int i = 0; i < vtx_cnt[p]; i++) begin
      d = longint'(poly_x[p][i]) * ax + longint'(poly_y[p][i]) * ay;
      if (i == 0 || d < lo) lo = d;
      if (i == 0 || d > hi) hi = d;
    end
  endfunction

  // true when some side normal of polygon p separates the two polygons
  function automatic bit side_separates(int p);
    longint dx, dy, a_lo, a_hi, b_lo, b_hi;
    int j;
    for (int i = 0; i < vtx_cnt[p]; i++) begin
      j  = (i + 1 < vtx_cnt[p]) ? i + 1 : 0;
      dx = longint'(poly_x[p][j]) - longint'(poly_x[p][i]);
      dy = longint'(poly_y[p][j]) - longint'(poly_y[p][i]);
      span_on_axis(0, dy, -dx, a_lo, a_hi);
      span_on_axis(1, dy, -dx, b_lo, b_hi);
      if (a_hi < b_lo || b_hi < a_lo) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit collide_vertex(cpsc_pkg::in_item_t v,
                                        output cpsc_pkg::out_item_t res);
    int p;
    p = v.polygon_b ? 1 : 0;
    res.colliding = 1'b0;
    res.status    = cpsc_pkg::STATUS_OK;
    // a new polygon A after A ended throws away the pair held so far
    if (!v.polygon_b && a_closed) begin
      vtx_cnt[0] = 0;
      vtx_cnt[1] = 0;
      a_closed   = 1'b0;
    end
    if (vtx_cnt[p] < cpsc_pkg::MAX_VERTICES) begin
      poly_x[p][vtx_cnt[p]] = v.x_coord;
      poly_y[p][vtx_cnt[p]] = v.y_coord;
      vtx_cnt[p]++;
    end else begin
      vtx_cnt[p] = cpsc_pkg::MAX_VERTICES + 1;
    end
    if (!v.polygon_b) begin
      if (v.last_vertex) a_closed = 1'b1;
      return 1'b0;
    end
    if (!v.last_vertex) return 1'b0;
    if (vtx_cnt[0] > cpsc_pkg::MAX_VERTICES || vtx_cnt[1] > cpsc_pkg::MAX_VERTICES)
      res.status = cpsc_pkg::STATUS_OVERFLOW;
    else if (vtx_cnt[0] < 2 || vtx_cnt[1] < 2)
      res.status = cpsc_pkg::STATUS_TOO_FEW;
    else
      res.colliding = !(side_separates(0) || side_separates(1));
    vtx_cnt[0] = 0;
    vtx_cnt[1] = 0;
    a_closed   = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [cpsc_pkg::COORD_BITS-1:0] clamp_coord(int v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return cpsc_pkg::COORD_BITS'(v);
  endfunction

  function automatic int pick_count();
    if ($urandom_range(0, 9) == 0) return $urandom_range(2, cpsc_pkg::MAX_VERTICES);
    return $urandom_range(2, 6);
  endfunction

  function automatic int jitter(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  task automatic add_vertex(bit is_b, int x, int y, bit closes);
    vertex_req_t req;
    req.item.polygon_b   = is_b;
    req.item.x_coord     = clamp_coord(x);
    req.item.y_coord     = clamp_coord(y);
    req.item.last_vertex = closes;
    req.wait_idle        = pause_next;
    pause_next           = 1'b0;
    vertex_q             = {vertex_q, req};
  endtask

  task automatic add_polygon(bit is_b, int n, int cx, int cy, int r, bit closes);
    for (int k = 0; k < n; k++)
      add_vertex(is_b, cx + jitter(r), cy + jitter(r), closes && k == n - 1);
  endtask

  task automatic add_pair();
    int na, nb, cx, cy, r, kind;
    bit a_open;
    kind   = $urandom_range(0, 99);
    na     = pick_count();
    nb     = pick_count();
    a_open = 1'b0;
    if ($urandom_range(0, 7) == 0) begin
      cx = 0;
      cy = 0;
      r  = COORD_MAX;
    end else begin
      cx = int'($urandom_range(0, 40000)) - 20000;
      cy = int'($urandom_range(0, 40000)) - 20000;
      r  = $urandom_range(8, 1500);
    end
    if (kind >= 75 && kind < 83) begin
      // overflow on one side
      if ($urandom_range(0, 1))
        na = $urandom_range(cpsc_pkg::MAX_VERTICES + 1, cpsc_pkg::MAX_VERTICES + 4);
      else
        nb = $urandom_range(cpsc_pkg::MAX_VERTICES + 1, cpsc_pkg::MAX_VERTICES + 4);
    end else if (kind >= 83 && kind < 89) begin
      if ($urandom_range(0, 1)) na = $urandom_range(0, 1);
      else nb = 1;
    end else if (kind >= 89 && kind < 95) begin
      // a complete A, maybe a partial B, both dropped by the restart
      add_polygon(1'b0, pick_count(), cx, cy, r, 1'b1);
      if ($urandom_range(0, 1)) add_polygon(1'b1, $urandom_range(1, 3), cx, cy, r, 1'b0);
    end else if (kind >= 95) begin
      a_open = 1'b1;
    end
    add_polygon(1'b0, na, cx, cy, r, !a_open);
    add_polygon(1'b1, nb, cx + jitter(3 * r), cy + jitter(3 * r), r, 1'b1);
  endtask

  // ---------------------------------------------------------------- driver
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        cpsc_pkg::out_item_t verdict;
        sent++;
        if (collide_vertex(in_data, verdict)) begin
          verdict_q = {verdict_q, verdict};
          if (verdict.status == cpsc_pkg::STATUS_OVERFLOW) n_ovf++;
          else if (verdict.status == cpsc_pkg::STATUS_TOO_FEW) n_few++;
          else if (verdict.colliding) n_hit++;
          else n_sep++;
        end
      end
      if (in_valid && !in_ready) begin
        // hold the offered vertex
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (vertex_q.size() != 0 &&
                   !(vertex_q[0].wait_idle && verdict_q.size() != 0)) begin
        in_valid <= 1'b1;
        in_data  <= vertex_q[0].item;
        void'(vertex_q.pop_front());
        gap_left = ((sent / 100) % 4 == 3) ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int                  stall_left;
  cpsc_pkg::out_item_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result transfer with no verdict pending: colliding %0d status %0d",
                 out_data.colliding, out_data.status);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data.colliding !== want.colliding) begin
            $error("colliding: expected %0d, got %0d", want.colliding, out_data.colliding);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
        end
        verdicts_seen++;
        // one long hold-off lets the next pair back up into the input
        if (verdicts_seen == 30) stall_left = LONG_HOLD;
        else stall_left = ((verdicts_seen / 20) % 4 == 3) ? 0 : $urandom_range(0, 15);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, verdict_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    // overlapping triangles
    add_vertex(1'b0, 0, 0, 1'b0);
    add_vertex(1'b0, 160, 0, 1'b0);
    add_vertex(1'b0, 0, 160, 1'b1);
    add_vertex(1'b1, 32, 32, 1'b0);
    add_vertex(1'b1, 300, 32, 1'b0);
    add_vertex(1'b1, 32, 300, 1'b1);
    // parallel segments at the coordinate extremes
    add_vertex(1'b0, COORD_MIN, COORD_MIN, 1'b0);
    add_vertex(1'b0, COORD_MAX, COORD_MIN, 1'b1);
    add_vertex(1'b1, COORD_MIN, COORD_MAX, 1'b0);
    add_vertex(1'b1, COORD_MAX, COORD_MAX, 1'b1);
    // polygon A with a single vertex
    add_vertex(1'b0, 0, 0, 1'b1);
    add_vertex(1'b1, 16, 16, 1'b0);
    add_vertex(1'b1, 48, 48, 1'b1);
    // repeated vertex gives a zero-length side
    add_vertex(1'b0, 16, 16, 1'b0);
    add_vertex(1'b0, 16, 16, 1'b0);
    add_vertex(1'b0, 48, 16, 1'b1);
    add_vertex(1'b1, 16, 16, 1'b0);
    add_vertex(1'b1, 40, 40, 1'b1);
    // A restarts after a partial B, then B closes while the new A is open
    add_vertex(1'b0, 0, 0, 1'b0);
    add_vertex(1'b0, 160, 0, 1'b1);
    add_vertex(1'b1, 7, 7, 1'b0);
    add_vertex(1'b0, 800, 800, 1'b0);
    add_vertex(1'b0, 960, 800, 1'b0);
    add_vertex(1'b0, 800, 960, 1'b0);
    add_vertex(1'b1, 880, 880, 1'b0);
    add_vertex(1'b1, 4000, 4000, 1'b1);

    pause_next = 1'b1;
    while (vertex_q.size() < N_ITEMS) begin
      if (vertex_q.size() >= N_ITEMS / 2 && vertex_q.size() < N_ITEMS / 2 + 8)
        pause_next = 1'b1;
      add_pair();
    end

    @(posedge rst_ni);
    while (vertex_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d vertices, checked %0d verdicts in %0d cycles", sent, verdicts_seen,
             cycles);
    $display("verdicts: %0d colliding, %0d separated, %0d too few, %0d overflow",
             n_hit, n_sep, n_few, n_ovf);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> convex_polygon_sat_collision.f
rtl/core/cpsc_pkg.sv
rtl/core/cpsc_lane.sv
rtl/core/cpsc_dp.sv
rtl/core/cpsc_ctrl.sv
rtl/core/convex_polygon_sat_collision.sv
rtl/core/cpsc_checker.sv
bench/convex_polygon_sat_collision_tb.sv
